// ===== src/smtc_pkg.sv =====
// Shared types, constants and saturating helpers for the sliding-mode thrust controller.
// Used by the multiplier, the divider and the top level; no dependencies.
package smtc_pkg;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int DTW       = 17;
  localparam int CFG_W     = 31;
  localparam int KI_W      = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DW-1:0] VMAX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN   = {1'b1, {(DW-1){1'b0}}};
  localparam logic        [DW-1:0] MAGLIM = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONEQ   = DW'(64'd1 << FB);

  // Fixed coefficients, rounded to nearest; T_SMALL is rounded up
  localparam logic signed [DW-1:0] J_A = DW'(((64'd25 << FB) + 64'd50) / 64'd100);
  localparam logic signed [DW-1:0] J_B = DW'(((64'd10638 << FB) + 64'd5000) / 64'd10000);
  localparam logic signed [DW-1:0] J_C = DW'(((64'd17857 << FB) + 64'd5000) / 64'd10000);
  localparam logic signed [DW-1:0] LAMBDA1 = DW'(((64'd1 << FB) + 64'd1) / 64'd2);
  localparam logic signed [DW-1:0] LAMBDA2 = DW'(((64'd1 << FB) + 64'd5) / 64'd10);
  localparam logic signed [DW-1:0] KI_MINOR = DW'(((64'd1 << FB) + 64'd5000) / 64'd10000);
  localparam logic signed [DW-1:0] RESTART_EPS = DW'(((64'd1 << FB) + 64'd500) / 64'd1000);
  localparam logic signed [DW-1:0] T_SMALL = DW'(((64'd1 << FB) + 64'd999999) / 64'd1000000);
  localparam int SURF_RATE = 1000;
  localparam logic signed [DW-1:0] DEN2_LIM =
    DW'((64'(VMAX) - 64'(ONEQ)) / 64'(SURF_RATE));

  // Square root result bits and divider steps
  localparam int SQ_BITS   = (DW - 1 + FB) / 2 + 2;
  localparam int SQ_CW     = $clog2(SQ_BITS);
  localparam int DIV_STEPS = DW + FB;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Register reset values
  localparam logic [CFG_W-1:0] RST_ALPHA_START    = CFG_W'(32768000);
  localparam logic [CFG_W-1:0] RST_ALPHA_FINAL    = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RST_APPROACH_SPEED = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RST_SEGMENT_SCALE  = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RST_THRUST_LIMIT   = CFG_W'(655360);
  localparam logic [CFG_W-1:0] RST_KD_SURGE       = CFG_W'(6553600);
  localparam logic [CFG_W-1:0] RST_KD_SWAY_YAW    = CFG_W'(327680);
  localparam logic [KI_W-1:0]  RST_KI_SURGE       = KI_W'(66);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_START    = 3'd0,
    REG_ALPHA_FINAL    = 3'd1,
    REG_APPROACH_SPEED = 3'd2,
    REG_SEGMENT_SCALE  = 3'd3,
    REG_THRUST_LIMIT   = 3'd4,
    REG_KD_SURGE       = 3'd5,
    REG_KD_SWAY_YAW    = 3'd6,
    REG_KI_SURGE       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] heading;
    logic signed [DW-1:0] target_x;
    logic signed [DW-1:0] target_y;
    logic signed [DW-1:0] target_heading;
    logic [DTW-1:0]       dt;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] thrust_0;
    logic signed [DW-1:0] thrust_1;
    logic signed [DW-1:0] thrust_2;
    logic signed [DW-1:0] thrust_3;
  } out_item_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic signed [DW-1:0] res;
    logic [DW-1:0]        mag;
    logic                 ovf;
  } mul_rsp_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] n;
    logic [DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] q;
  } div_rsp_t;

  function automatic logic signed [DW-1:0] sat_wide(input logic signed [DW+1:0] x);
    logic signed [DW+1:0] hi;
    logic signed [DW+1:0] lo;
    hi = {2'b00, VMAX};
    lo = {2'b11, VMIN};
    if (x > hi) begin
      return VMAX;
    end else if (x < lo) begin
      return VMIN;
    end
    return x[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] add_sat(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW+1:0] s;
    s = {{2{a[DW-1]}}, a} + {{2{b[DW-1]}}, b};
    return sat_wide(s);
  endfunction

  function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW+1:0] s;
    s = {{2{a[DW-1]}}, a} - {{2{b[DW-1]}}, b};
    return sat_wide(s);
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

endpackage

// ===== src/sliding_mode_thrust_controller_core.sv =====
// Super-twisting sliding-mode thrust controller: one control sample in, four thruster
// forces out, Q16.16. A sequencer drives one shared 32x32 multiplier and one
// bit-serial divider. Each of the three square roots takes an issue and a check step per
// result bit (25 bits). Up to five quotients are waited for: the approach time on a fresh
// sample and the gain decay ratio inside the approach time, and each axis always runs
// one surface decay.
// The input is stalled while an item is in work; a finished result waits in the
// output register, so the next item can be taken before it is read.
module sliding_mode_thrust_controller_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  smtc_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output smtc_pkg::out_item_t                  out_data,
  input  logic                                 cfg_en,
  input  logic [smtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smtc_pkg::CFG_W-1:0]           cfg_data
);
  import smtc_pkg::*;

  typedef enum logic [30:0] {
    S_IDLE     = 31'(1) << 0,
    S_DERR     = 31'(1) << 1,
    S_SQ_ISSUE = 31'(1) << 2,
    S_SQ_CHK   = 31'(1) << 3,
    S_D_L1     = 31'(1) << 4,
    S_D_DRV    = 31'(1) << 5,
    S_D_EST    = 31'(1) << 6,
    S_D_ESTW   = 31'(1) << 7,
    S_D_RATE   = 31'(1) << 8,
    S_APP      = 31'(1) << 9,
    S_APP_W    = 31'(1) << 10,
    S_DEN      = 31'(1) << 11,
    S_DEN_W    = 31'(1) << 12,
    S_R_W      = 31'(1) << 13,
    S_FRAC     = 31'(1) << 14,
    S_AL_ISSUE = 31'(1) << 15,
    S_AL_W     = 31'(1) << 16,
    S_SURF     = 31'(1) << 17,
    S_CUR      = 31'(1) << 18,
    S_SDIV     = 31'(1) << 19,
    S_SD_W     = 31'(1) << 20,
    S_SI       = 31'(1) << 21,
    S_SR_ISSUE = 31'(1) << 22,
    S_SR_W     = 31'(1) << 23,
    S_TAU      = 31'(1) << 24,
    S_TAU_W    = 31'(1) << 25,
    S_J0       = 31'(1) << 26,
    S_J1       = 31'(1) << 27,
    S_J2       = 31'(1) << 28,
    S_J3       = 31'(1) << 29,
    S_FORM     = 31'(1) << 30
  } state_t;

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  state_t state;

  // Configuration
  logic [CFG_W-1:0] alpha_start;
  logic [CFG_W-1:0] alpha_final;
  logic [CFG_W-1:0] approach_speed;
  logic [CFG_W-1:0] segment_scale;
  logic [CFG_W-1:0] thrust_limit;
  logic [CFG_W-1:0] kd_surge;
  logic [CFG_W-1:0] kd_sway_yaw;
  logic [KI_W-1:0]  ki_surge;

  // Controller state
  logic signed [DW-1:0] est       [3];
  logic signed [DW-1:0] rate      [3];
  logic signed [DW-1:0] sint      [3];
  logic signed [DW-1:0] init_surf [3];
  logic signed [DW-1:0] elapsed;
  logic signed [DW-1:0] approach;
  logic signed [DW-1:0] last_tx;

  // Working registers
  logic signed [DW-1:0] e   [3];
  logic signed [DW-1:0] tau [3];
  logic [DTW-1:0]       dtq;
  logic                 fresh;
  logic [1:0]           ax;
  logic [SQ_CW-1:0]     bitc;
  logic [SQ_BITS-1:0]   y;
  logic [DW-1:0]        xmag;
  logic                 sg_pos;
  logic                 sg_neg;
  logic signed [DW-1:0] tmp;
  logic signed [DW-1:0] den2;
  logic signed [DW-1:0] adiff;
  logic signed [DW-1:0] alpha;
  logic signed [DW-1:0] cur;
  logic signed [DW-1:0] se;
  logic signed [DW-1:0] ja;
  logic signed [DW-1:0] jb;
  logic signed [DW-1:0] jc;
  logic signed [DW-1:0] psum;
  logic signed [DW-1:0] pdif;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 in_acc;
  logic                 out_load;
  logic signed [DW-1:0] e_in [3];
  logic signed [DW-1:0] tx_dev;
  logic                 restart;
  logic [DW:0]          t_sum;
  logic signed [DW-1:0] t_next;
  logic [SQ_BITS-1:0]   sq_cand;
  logic signed [DW-1:0] err_cur;
  logic [DW+9:0]        t1000;
  logic signed [DW-1:0] den2_val;
  logic signed [DW-1:0] den_val;
  logic signed [DW-1:0] qsign;
  logic signed [DW-1:0] lim;

  smtc_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  smtc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_FORM) && (!out_valid || !out_stall);

  always_comb begin
    e_in[0] = sub_sat(in_data.pos_x, in_data.target_x);
    e_in[1] = sub_sat(in_data.pos_y, in_data.target_y);
    e_in[2] = sub_sat(in_data.heading, in_data.target_heading);
    tx_dev  = sub_sat(last_tx, in_data.target_x);
    restart = (tx_dev > RESTART_EPS) || (tx_dev < -RESTART_EPS);
    t_sum   = {1'b0, elapsed} + (DW+1)'(in_data.dt);
    if (restart) begin
      t_next = '0;
    end else if (t_sum > {1'b0, VMAX}) begin
      t_next = VMAX;
    end else begin
      t_next = $signed(t_sum[DW-1:0]);
    end
    sq_cand  = y | (SQ_BITS'(1) << bitc);
    err_cur  = sub_sat(e[ax], est[ax]);
    t1000    = (DW+10)'($unsigned(elapsed)) * (DW+10)'(SURF_RATE);
    den2_val = (elapsed > DEN2_LIM) ? VMAX : $signed(t1000[DW-1:0] + ONEQ);
    den_val  = (mul_rsp.res < $signed(DW'(1))) ? $signed(DW'(1)) : mul_rsp.res;
    qsign    = init_surf[ax][DW-1] ? -div_rsp.q : div_rsp.q;
    lim      = $signed(DW'(thrust_limit));
  end

  // Multiplier operand select
  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    case (state)
      S_SQ_ISSUE: begin
        mul_req.a = $signed(DW'(sq_cand));
        mul_req.b = $signed(DW'(sq_cand));
      end
      S_D_L1: begin
        mul_req.a = $signed(DW'(y));
        mul_req.b = LAMBDA1;
      end
      S_D_EST: begin
        mul_req.a = tmp;
        mul_req.b = $signed(DW'(dtq));
      end
      S_D_ESTW: begin
        mul_req.a = LAMBDA2;
        mul_req.b = $signed(DW'(dtq));
      end
      S_DEN: begin
        mul_req.a = $signed(DW'(segment_scale));
        mul_req.b = approach;
      end
      S_R_W: begin
        mul_req.a = div_rsp.q;
        mul_req.b = div_rsp.q;
      end
      S_AL_ISSUE: begin
        mul_req.a = adiff;
        mul_req.b = tmp;
      end
      S_SURF: begin
        mul_req.a = alpha;
        mul_req.b = e[ax];
      end
      S_SR_ISSUE: begin
        mul_req.a = (ax == 2'd0) ? $signed(DW'(ki_surge)) : KI_MINOR;
        mul_req.b = sint[ax];
      end
      S_TAU: begin
        mul_req.a = (ax == 2'd0) ? $signed(DW'(kd_surge)) : $signed(DW'(kd_sway_yaw));
        mul_req.b = tmp;
      end
      S_J0: begin
        mul_req.a = J_A;
        mul_req.b = tau[0];
      end
      S_J1: begin
        mul_req.a = J_B;
        mul_req.b = tau[1];
      end
      S_J2: begin
        mul_req.a = J_C;
        mul_req.b = tau[2];
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // Divider request select
  always_comb begin
    div_req.start = 1'b0;
    div_req.n     = '0;
    div_req.d     = '0;
    case (state)
      S_APP: begin
        div_req.start = fresh;
        div_req.n     = mag(e[0]);
        div_req.d     = DW'(approach_speed);
      end
      S_DEN_W: begin
        div_req.start = (elapsed <= approach);
        div_req.n     = $unsigned(elapsed);
        div_req.d     = $unsigned(den_val);
      end
      S_SDIV: begin
        div_req.start = 1'b1;
        div_req.n     = mag(init_surf[ax]);
        div_req.d     = $unsigned(den2);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_start    <= RST_ALPHA_START;
      alpha_final    <= RST_ALPHA_FINAL;
      approach_speed <= RST_APPROACH_SPEED;
      segment_scale  <= RST_SEGMENT_SCALE;
      thrust_limit   <= RST_THRUST_LIMIT;
      kd_surge       <= RST_KD_SURGE;
      kd_sway_yaw    <= RST_KD_SWAY_YAW;
      ki_surge       <= RST_KI_SURGE;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_ALPHA_START:    alpha_start    <= cfg_data;
        REG_ALPHA_FINAL:    alpha_final    <= cfg_data;
        REG_APPROACH_SPEED: approach_speed <= cfg_data;
        REG_SEGMENT_SCALE:  segment_scale  <= cfg_data;
        REG_THRUST_LIMIT:   thrust_limit   <= cfg_data;
        REG_KD_SURGE:       kd_surge       <= cfg_data;
        REG_KD_SWAY_YAW:    kd_sway_yaw    <= cfg_data;
        REG_KI_SURGE:       ki_surge       <= cfg_data[KI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ax       <= '0;
      bitc     <= '0;
      elapsed  <= VMAX;
      approach <= '0;
      last_tx  <= '0;
      for (int i = 0; i < 3; i++) begin
        est[i]       <= '0;
        rate[i]      <= '0;
        sint[i]      <= '0;
        init_surf[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
              e[i] <= e_in[i];
            end
            dtq     <= in_data.dt;
            elapsed <= t_next;
            fresh   <= (t_next < T_SMALL);
            last_tx <= in_data.target_x;
            ax      <= '0;
            state   <= S_DERR;
          end
        end
        S_DERR: begin
          xmag   <= mag(err_cur);
          sg_pos <= (err_cur > 0);
          sg_neg <= (err_cur < 0);
          y      <= '0;
          bitc   <= SQ_CW'(SQ_BITS - 1);
          state  <= S_SQ_ISSUE;
        end
        S_SQ_ISSUE: begin
          state <= S_SQ_CHK;
        end
        S_SQ_CHK: begin
          // keep the candidate bit when its square still fits under the error
          if (!mul_rsp.ovf && (mul_rsp.mag <= xmag)) begin
            y <= sq_cand;
          end
          if (bitc == '0) begin
            state <= S_D_L1;
          end else begin
            bitc  <= bitc - 1'b1;
            state <= S_SQ_ISSUE;
          end
        end
        S_D_L1: begin
          state <= S_D_DRV;
        end
        S_D_DRV: begin
          if (sg_pos) begin
            tmp <= add_sat(rate[ax], mul_rsp.res);
          end else if (sg_neg) begin
            tmp <= sub_sat(rate[ax], mul_rsp.res);
          end else begin
            tmp <= rate[ax];
          end
          state <= S_D_EST;
        end
        S_D_EST: begin
          state <= S_D_ESTW;
        end
        S_D_ESTW: begin
          est[ax] <= add_sat(est[ax], mul_rsp.res);
          state   <= S_D_RATE;
        end
        S_D_RATE: begin
          if (sg_pos) begin
            rate[ax] <= add_sat(rate[ax], mul_rsp.res);
          end else if (sg_neg) begin
            rate[ax] <= sub_sat(rate[ax], mul_rsp.res);
          end
          if (ax == 2'd2) begin
            ax    <= '0;
            state <= S_APP;
          end else begin
            ax    <= ax + 1'b1;
            state <= S_DERR;
          end
        end
        S_APP: begin
          den2  <= den2_val;
          adiff <= $signed(DW'(alpha_start)) - $signed(DW'(alpha_final));
          state <= fresh ? S_APP_W : S_DEN;
        end
        S_APP_W: begin
          if (div_rsp.done) begin
            approach <= div_rsp.q;
            state    <= S_DEN;
          end
        end
        S_DEN: begin
          state <= S_DEN_W;
        end
        S_DEN_W: begin
          if (elapsed <= approach) begin
            state <= S_R_W;
          end else begin
            alpha <= $signed(DW'(alpha_final));
            state <= S_SURF;
          end
        end
        S_R_W: begin
          if (div_rsp.done) begin
            state <= S_FRAC;
          end
        end
        S_FRAC: begin
          tmp   <= sub_sat(ONEQ, mul_rsp.res);
          state <= S_AL_ISSUE;
        end
        S_AL_ISSUE: begin
          state <= S_AL_W;
        end
        S_AL_W: begin
          alpha <= add_sat($signed(DW'(alpha_final)), mul_rsp.res);
          state <= S_SURF;
        end
        S_SURF: begin
          state <= S_CUR;
        end
        S_CUR: begin
          cur <= add_sat(rate[ax], mul_rsp.res);
          if (fresh) begin
            init_surf[ax] <= add_sat(rate[ax], mul_rsp.res);
          end
          state <= S_SDIV;
        end
        S_SDIV: begin
          state <= S_SD_W;
        end
        S_SD_W: begin
          if (div_rsp.done) begin
            se    <= sub_sat(cur, qsign);
            state <= S_SI;
          end
        end
        S_SI: begin
          if (se > 0) begin
            sint[ax] <= add_sat(sint[ax], $signed(DW'(dtq)));
          end else if (se < 0) begin
            sint[ax] <= sub_sat(sint[ax], $signed(DW'(dtq)));
          end
          state <= S_SR_ISSUE;
        end
        S_SR_ISSUE: begin
          state <= S_SR_W;
        end
        S_SR_W: begin
          tmp   <= add_sat(se, mul_rsp.res);
          state <= S_TAU;
        end
        S_TAU: begin
          state <= S_TAU_W;
        end
        S_TAU_W: begin
          tau[ax] <= mul_rsp.res;
          if (ax == 2'd2) begin
            state <= S_J0;
          end else begin
            ax    <= ax + 1'b1;
            state <= S_SURF;
          end
        end
        S_J0: begin
          state <= S_J1;
        end
        S_J1: begin
          ja    <= mul_rsp.res;
          state <= S_J2;
        end
        S_J2: begin
          jb    <= mul_rsp.res;
          state <= S_J3;
        end
        S_J3: begin
          jc    <= mul_rsp.res;
          psum  <= add_sat(ja, jb);
          pdif  <= sub_sat(ja, jb);
          state <= S_FORM;
        end
        S_FORM: begin
          // hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.thrust_0 <= clamp(sub_sat(psum, jc), lim);
      out_data.thrust_1 <= clamp(sub_sat(pdif, jc), lim);
      out_data.thrust_2 <= clamp(add_sat(pdif, jc), lim);
      out_data.thrust_3 <= clamp(add_sat(psum, jc), lim);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input not stalled after an item was accepted");

  a_result_from_form: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FORM))
    else $error("result raised outside the final step");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_APP_W || state == S_R_W || state == S_SD_W))
    else $error("divider finished while the sequencer was not waiting");

  a_form_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FORM && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished item not moved into the output register");

endmodule

// ===== src/smtc_mul.sv =====
// Shared fixed-point multiplier: truncated magnitude product, saturated, registered.
// Depends on smtc_pkg.
module smtc_mul (
  input  logic              clk,
  input  smtc_pkg::mul_req_t req,
  output smtc_pkg::mul_rsp_t rsp
);
  import smtc_pkg::*;

  logic [DW-1:0]        ma;
  logic [DW-1:0]        mb;
  logic [2*DW-1:0]      prod;
  logic [2*DW-FB-1:0]   shr;
  logic                 ovf;
  logic [DW-1:0]        m;
  logic signed [DW-1:0] res;

  always_comb begin
    ma   = mag(req.a);
    mb   = mag(req.b);
    prod = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
    shr  = prod[2*DW-1:FB];
    ovf  = shr > (2*DW-FB)'(MAGLIM);
    m    = ovf ? MAGLIM : shr[DW-1:0];
    if (req.a[DW-1] ^ req.b[DW-1]) begin
      res = -$signed(m);
    end else if (m[DW-1]) begin
      res = VMAX;
    end else begin
      res = $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    rsp.res <= res;
    rsp.mag <= m;
    rsp.ovf <= ovf;
  end

endmodule

// ===== src/smtc_div.sv =====
// Restoring divider, one quotient bit per cycle: (n << FB) / d, saturated, zero divisor to max.
// Depends on smtc_pkg.
module smtc_div (
  input  logic              clk,
  input  logic              rst,
  input  smtc_pkg::div_req_t req,
  output smtc_pkg::div_rsp_t rsp
);
  import smtc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CW-1:0]    cnt;
  logic [DW-1:0]        rem;
  logic [DIV_STEPS-1:0] num;
  logic [DIV_STEPS-1:0] quo;
  logic [DW-1:0]        dreg;
  logic                 dzero;
  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 ge;

  always_comb begin
    trial = {rem, num[DIV_STEPS-1]};
    diff  = trial - {1'b0, dreg};
    ge    = trial >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= '0;
      num   <= {req.n, {FB{1'b0}}};
      quo   <= '0;
      dreg  <= req.d;
      dzero <= (req.d == '0);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num <= {num[DIV_STEPS-2:0], 1'b0};
      quo <= {quo[DIV_STEPS-2:0], ge};
    end
  end

  always_comb begin
    rsp.done = done;
    if (dzero || (quo > {{FB{1'b0}}, VMAX})) begin
      rsp.q = VMAX;
    end else begin
      rsp.q = $signed(quo[DW-1:0]);
    end
  end

endmodule

// ===== bench/thrust_checker.sv =====
// Checker for the sliding-mode thrust controller: watches the config port and both channels.
// It predicts the four thruster forces per control sample and compares them in order.
// Depends on smtc_pkg for the item types and fixed coefficients.
`timescale 1ns / 100ps

module thrust_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  smtc_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  smtc_pkg::out_item_t             out_data,
  input  logic                            cfg_en,
  input  logic [smtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smtc_pkg::CFG_W-1:0]      cfg_data,
  output int                              fails,
  output int                              pending
);
  import smtc_pkg::*;

  localparam longint VHI = 64'sd2147483647;
  localparam longint VLO = -64'sd2147483648;
  localparam longint unsigned MAG_CAP = 64'd1 << 31;
  localparam longint unsigned HMASK = 64'hFFFFFF;
  localparam longint ONE_Q = 64'sd65536;

  // controller state
  longint est[3], rate[3], sgn_int[3], surf0[3];
  longint elapsed, appr_time, last_tx;
  // registers
  longint r_alpha_start, r_alpha_final, r_speed, r_seg, r_limit, r_kd_surge, r_kd_sy, r_ki;

  out_item_t thrust_expected[$];

  function automatic longint clip(longint x);
    return x > VHI ? VHI : (x < VLO ? VLO : x);
  endfunction

  function automatic longint sgn(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic longint unsigned absv(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  // truncated Q product of magnitudes, capped at 2^31
  function automatic longint unsigned qmul_mag(longint unsigned a, longint unsigned b,
                                               output bit ovf);
    longint unsigned al, ah, bl, bh, lo, mid, hi, t, h, r;
    al = a & HMASK; ah = (a >> 24) & HMASK;
    bl = b & HMASK; bh = (b >> 24) & HMASK;
    lo = al * bl; mid = ah * bl + al * bh; hi = ah * bh;
    t = lo + ((mid & HMASK) << 24);
    h = hi + (mid >> 24);
    ovf = 1'b1;
    if (h > (MAG_CAP >> 32)) return MAG_CAP;
    r = (h << 32) + (t >> 16);
    if (r > MAG_CAP) return MAG_CAP;
    ovf = 1'b0;
    return r;
  endfunction

  function automatic longint qmul(longint a, longint b);
    bit o;
    longint m;
    m = longint'(qmul_mag(absv(a), absv(b), o));
    return ((a < 0) != (b < 0)) ? clip(-m) : clip(m);
  endfunction

  function automatic longint unsigned qdiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    if (d == 0) return VHI;
    q = n / d;
    r = n % d;
    if (q > (longint'(VHI) >> 16)) return VHI;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q > VHI ? VHI : q;
  endfunction

  function automatic longint qdiv_signed(longint a, longint unsigned d);
    longint q;
    q = longint'(qdiv(absv(a), d));
    return a < 0 ? -q : q;
  endfunction

  function automatic longint qsqrt(longint unsigned x);
    longint unsigned y, c, r;
    bit o;
    y = 0;
    for (int b = 24; b >= 0; b--) begin
      c = y | (64'd1 << b);
      r = qmul_mag(c, c, o);
      if (!o && r <= x) y = c;
    end
    return y > VHI ? VHI : longint'(y);
  endfunction

  function automatic out_item_t predict_thrust(in_item_t it);
    longint pose[3], tgt[3], e[3], tau[3], f[4];
    longint dtq, t, alpha, den, den2, err, sg, drive, cur, se, sr, v, col_b, col_c;
    longint unsigned den_u, rq, r2;
    bit o, fresh;
    out_item_t res;
    pose[0] = it.pos_x; pose[1] = it.pos_y; pose[2] = it.heading;
    tgt[0] = it.target_x; tgt[1] = it.target_y; tgt[2] = it.target_heading;
    for (int i = 0; i < 3; i++) e[i] = clip(pose[i] - tgt[i]);
    dtq = longint'(it.dt);

    if (absv(clip(last_tx - tgt[0])) > longint'(RESTART_EPS)) t = 0;
    else t = (elapsed > VHI - dtq) ? VHI : elapsed + dtq;
    elapsed = t;

    for (int i = 0; i < 3; i++) begin
      err = clip(e[i] - est[i]);
      sg = sgn(err);
      drive = clip(rate[i] + sg * qmul(qsqrt(absv(err)), longint'(LAMBDA1)));
      est[i] = clip(est[i] + qmul(drive, dtq));
      rate[i] = clip(rate[i] + sg * qmul(longint'(LAMBDA2), dtq));
    end

    fresh = t < longint'(T_SMALL);
    if (fresh) appr_time = longint'(qdiv(absv(e[0]), r_speed));

    den_u = qmul_mag(r_seg, appr_time, o);
    den = den_u > VHI ? VHI : longint'(den_u);
    if (den < 1) den = 1;
    if (t <= appr_time) begin
      rq = qdiv(t, den);
      r2 = qmul_mag(rq, rq, o);
      alpha = clip(r_alpha_final + qmul(clip(r_alpha_start - r_alpha_final),
                   clip(ONE_Q - (r2 > VHI ? VHI : longint'(r2)))));
    end else begin
      alpha = r_alpha_final;
    end

    den2 = (t > (VHI - ONE_Q) / 1000) ? VHI : ONE_Q + 1000 * t;
    for (int i = 0; i < 3; i++) begin
      cur = clip(rate[i] + qmul(alpha, e[i]));
      if (fresh) surf0[i] = cur;
      se = clip(cur - qdiv_signed(surf0[i], den2));
      sgn_int[i] = clip(sgn_int[i] + sgn(se) * dtq);
      sr = clip(se + qmul(i == 0 ? r_ki : longint'(KI_MINOR), sgn_int[i]));
      tau[i] = qmul(i == 0 ? r_kd_surge : r_kd_sy, sr);
    end

    for (int i = 0; i < 4; i++) begin
      col_b = (i == 0 || i == 3) ? 1 : -1;
      col_c = (i >= 2) ? 1 : -1;
      v = qmul(longint'(J_A), tau[0]);
      v = clip(v + col_b * qmul(longint'(J_B), tau[1]));
      v = clip(v + col_c * qmul(longint'(J_C), tau[2]));
      if (v > r_limit) v = r_limit;
      if (v < -r_limit) v = -r_limit;
      f[i] = v;
    end
    last_tx = tgt[0];
    res.thrust_0 = f[0][31:0];
    res.thrust_1 = f[1][31:0];
    res.thrust_2 = f[2][31:0];
    res.thrust_3 = f[3][31:0];
    return res;
  endfunction

  assign pending = thrust_expected.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        est[i] = 0; rate[i] = 0; sgn_int[i] = 0; surf0[i] = 0;
      end
      elapsed = VHI; appr_time = 0; last_tx = 0;
      r_alpha_start = RST_ALPHA_START; r_alpha_final = RST_ALPHA_FINAL;
      r_speed = RST_APPROACH_SPEED; r_seg = RST_SEGMENT_SCALE;
      r_limit = RST_THRUST_LIMIT; r_kd_surge = RST_KD_SURGE;
      r_kd_sy = RST_KD_SWAY_YAW; r_ki = RST_KI_SURGE;
      thrust_expected.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_ALPHA_START:    r_alpha_start = cfg_data;
          REG_ALPHA_FINAL:    r_alpha_final = cfg_data;
          REG_APPROACH_SPEED: r_speed = cfg_data;
          REG_SEGMENT_SCALE:  r_seg = cfg_data;
          REG_THRUST_LIMIT:   r_limit = cfg_data;
          REG_KD_SURGE:       r_kd_surge = cfg_data;
          REG_KD_SWAY_YAW:    r_kd_sy = cfg_data;
          REG_KI_SURGE:       r_ki = cfg_data[KI_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) thrust_expected.push_back(predict_thrust(in_data));
      if (out_valid && !out_stall) begin
        if (thrust_expected.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected item: %h", out_data);
        end else begin
          want = thrust_expected.pop_front();
          if (want.thrust_0 !== out_data.thrust_0 || want.thrust_1 !== out_data.thrust_1 ||
              want.thrust_2 !== out_data.thrust_2 || want.thrust_3 !== out_data.thrust_3) begin
            fails++;
            if (fails <= 10)
              $display("thrust mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       want.thrust_0, want.thrust_1, want.thrust_2, want.thrust_3,
                       out_data.thrust_0, out_data.thrust_1, out_data.thrust_2,
                       out_data.thrust_3);
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, register programming, control samples and output stalls.
// Depends on smtc_pkg, the controller core and thrust_checker, which does all comparing.
`timescale 1ns / 100ps

module testbench;
  import smtc_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int SETTLE = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fails, pending;
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int stall_mode = 0, stall_left = 0;
  logic signed [DW-1:0] track_tx = '0;

  sliding_mode_thrust_controller_core u_top (.*);

  thrust_checker u_check (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls on its own changing pattern: none, coin flip, mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 300);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic cfg_write(cfg_reg_t r, logic [CFG_W-1:0] v);
    cfg_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] a_s, logic [CFG_W-1:0] a_f,
                              logic [CFG_W-1:0] spd, logic [CFG_W-1:0] seg,
                              logic [CFG_W-1:0] lim, logic [CFG_W-1:0] kds,
                              logic [CFG_W-1:0] kdy, logic [CFG_W-1:0] ki);
    cfg_write(REG_ALPHA_START, a_s);
    cfg_write(REG_ALPHA_FINAL, a_f);
    cfg_write(REG_APPROACH_SPEED, spd);
    cfg_write(REG_SEGMENT_SCALE, seg);
    cfg_write(REG_THRUST_LIMIT, lim);
    cfg_write(REG_KD_SURGE, kds);
    cfg_write(REG_KD_SWAY_YAW, kdy);
    cfg_write(REG_KI_SURGE, ki);
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  // hold valid through bursts, drop it for random gaps between them
  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_item_t mk(int px, int py, int ph, int tx, int ty, int th, int dt);
    in_item_t it;
    it.pos_x = px; it.pos_y = py; it.heading = ph;
    it.target_x = tx; it.target_y = ty; it.target_heading = th;
    it.dt = dt[DTW-1:0];
    return it;
  endfunction

  function automatic logic signed [DW-1:0] near(logic signed [DW-1:0] c);
    return c + $signed($urandom_range(0, 2 ** 21)) - (2 ** 20);
  endfunction

  // mostly a steady trajectory with occasional target moves; some raw noise
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 17'($urandom)};
    end else begin
      if (pick < 15) track_tx = near(0);
      else if (pick < 19) track_tx = track_tx + $signed($urandom_range(0, 140)) - 70;
      it.target_x = track_tx;
      it.target_y = near(0);
      it.target_heading = near(0);
      it.pos_x = near(track_tx);
      it.pos_y = near(it.target_y);
      it.heading = near(it.target_heading);
      it.dt = ($urandom_range(0, 19) == 0) ? 17'($urandom) : 17'($urandom_range(0, 1400));
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send(rand_item());
    drain();
  endtask

  initial begin
    logic [CFG_W-1:0] mx;
    mx = '1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, extremes, restart threshold, zero error, dt edges
    send(mk(0, 0, 0, 0, 0, 0, 655));
    send(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
            32'h80000000, 65536));
    send(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 17'h1ffff));
    send(mk(65536, -65536, 1000, 0, 0, 0, 0));
    send(mk(65536, -65536, 1000, 0, 0, 0, 0));
    send(mk(65536, -65536, 1000, 66, 0, 0, 655));
    send(mk(65536, -65536, 1000, 132, 0, 0, 655));
    send(mk(65536, -65536, 1000, 199, 0, 0, 655));
    send(mk(655360, 5, -5, 0, 0, 0, 1));
    for (int i = 0; i < 6; i++) send(mk(300000 - i * 40000, 20000, -30000, 0, 0, 0, 655));
    send(mk(0, 0, 0, 0, 0, 0, 17'h1ffff));
    send(mk(-1, 1, -1, 0, 0, 0, 65536));
    send(mk(1234567, 0, 0, 1234567, 0, 0, 0));
    drain();

    program_regs(mx, mx, mx, mx, mx, mx, mx, 65536);
    send(mk(32'h7fffffff, 32'h80000000, 7, 32'h80000000, 32'h7fffffff, 0, 17'h1ffff));
    send(mk(1 << 20, -(1 << 20), 3, 0, 0, 0, 655));
    random_phase(150);

    program_regs('0, '0, '0, '0, '0, '0, '0, '0);
    send(mk(1 << 20, -(1 << 20), 3, 1 << 22, 0, 0, 655));
    random_phase(150);

    program_regs(RST_ALPHA_START, RST_ALPHA_FINAL, RST_APPROACH_SPEED, RST_SEGMENT_SCALE,
                 RST_THRUST_LIMIT, RST_KD_SURGE, RST_KD_SWAY_YAW, RST_KI_SURGE);
    random_phase(250);

    for (int p = 0; p < 5; p++) begin
      program_regs($urandom_range(0, 1 << 26), $urandom_range(0, 1 << 19),
                   $urandom_range(1, 1 << 19), $urandom_range(0, 1 << 19),
                   (p == 4) ? 31'($urandom) : $urandom_range(1 << 14, 1 << 26),
                   $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 22),
                   (p == 3) ? 31'($urandom_range(0, 131071)) : $urandom_range(0, 65536));
      random_phase(150);
    end

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
